FILE: rtl/core/drl_pkg.sv
// Shared types and constants for the dense rank lookup block.
`default_nettype none
package drl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int SCORE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int RANK_W      = 11;
  localparam int ACTION_W    = 2;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_SHRD,
    S_SHWR,
    S_PUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/dense_rank_lookup.sv
// Dense rank lookup over a sorted set of distinct scores held in one RAM.
`default_nettype none
// The block keeps up to TABLE_DEPTH distinct scores in ascending order in a
// single-port-write, single-port-read RAM with a registered read, and takes
// one input word at a time (in_ready is high only when idle). A clear word
// empties the set and clears the overflow flag. Insert and query words run
// a binary search that reuses one comparator against the RAM read port,
// each probe passing through the PROBE and CMP states. A query then writes
// its result word to the output register (waiting there if the previous
// result has not been taken). A new score sent to a full table is dropped
// and sets the overflow flag; else every stored score above it moves up one
// place (a SHRD read and a SHWR write per entry), then PUT writes the new
// score. No clearing pass is needed: only the first count entries are ever read.
module dense_rank_lookup
  import drl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [ACTION_W-1:0]    in_action,
  input  wire logic [31:0]            in_score,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [RANK_W-1:0]           out_rank,
  output logic                        out_overflowed
);

  state_t                 state_r, state_nxt;
  logic [ACTION_W-1:0]    op_r;
  logic [SCORE_WIDTH-1:0] score_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   ovf_r;
  logic [CNT_W-1:0]       lo_r, hi_r, mid_r, mid_c;
  logic                   eq_r;
  logic [ADDR_W-1:0]      idx_r;
  logic                   out_valid_r, out_ovf_r;
  logic [RANK_W-1:0]      out_rank_r;

  logic [SCORE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [SCORE_WIDTH-1:0] rdata_r;
  logic [ADDR_W-1:0]      raddr, waddr;
  logic [SCORE_WIDTH-1:0] wdata;
  logic                   mem_we;

  logic                   in_fire, out_free, full;
  logic                   res_load;
  logic [CNT_W-1:0]       greater_c;
  logic [RANK_W-1:0]      rank_c;

  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign full           = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign out_valid      = out_valid_r;
  assign out_rank       = out_rank_r;
  assign out_overflowed = out_ovf_r;

  // Load the result register when a query finishes and the register is free
  assign res_load = (state_r == S_DECIDE) && (op_r == ACT_QUERY) && out_free;

  // Midpoint of the current search window
  assign mid_c = lo_r + ((hi_r - lo_r) >> 1);

  // Count scores strictly above the query: skip the entry equal to it
  assign greater_c = cnt_r - lo_r - CNT_W'(eq_r);
  assign rank_c    = RANK_W'(greater_c + CNT_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_action == ACT_INSERT || in_action == ACT_QUERY)) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: state_nxt = (lo_r == hi_r) ? S_DECIDE : S_CMP;
      S_CMP:   state_nxt = S_PROBE;
      S_DECIDE: begin
        if (op_r == ACT_QUERY) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (eq_r || full) begin
          state_nxt = S_IDLE;
        end else if (lo_r == cnt_r) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_SHRD:  state_nxt = S_SHWR;
      S_SHWR:  state_nxt = (idx_r == lo_r[ADDR_W-1:0]) ? S_PUT : S_SHRD;
      S_PUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM port controls
  always_comb begin
    raddr  = mid_c[ADDR_W-1:0];
    waddr  = lo_r[ADDR_W-1:0];
    wdata  = score_r;
    mem_we = 1'b0;
    unique case (state_r)
      S_SHRD: raddr = idx_r;
      S_SHWR: begin
        mem_we = 1'b1;
        waddr  = idx_r + ADDR_W'(1);
        wdata  = rdata_r;
      end
      S_PUT:  mem_we = 1'b1;
      default: ;
    endcase
  end

  // Score RAM with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && !res_load) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_action;
            score_r <= in_score[SCORE_WIDTH-1:0];
            lo_r    <= '0;
            hi_r    <= cnt_r;
            eq_r    <= 1'b0;
            if (in_action == ACT_CLEAR) begin
              cnt_r <= '0;
              ovf_r <= 1'b0;
            end
          end
        end
        S_PROBE: mid_r <= mid_c;
        S_CMP: begin
          // Narrow the window; note equality at each upper-bound move
          if (rdata_r < score_r) begin
            lo_r <= mid_r + CNT_W'(1);
          end else begin
            hi_r <= mid_r;
            eq_r <= (rdata_r == score_r);
          end
        end
        S_DECIDE: begin
          if (op_r == ACT_QUERY) begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_rank_r  <= rank_c;
              out_ovf_r   <= ovf_r;
            end
          end else if (!eq_r && full) begin
            ovf_r <= 1'b1;
          end else begin
            idx_r <= ADDR_W'(cnt_r - CNT_W'(1));
          end
        end
        S_SHWR: begin
          if (idx_r != lo_r[ADDR_W-1:0]) idx_r <= idx_r - ADDR_W'(1);
        end
        S_PUT: cnt_r <= cnt_r + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Stored count never exceeds the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("stored count beyond table depth");

  // Search window stays ordered and inside the stored range
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> (lo_r <= hi_r && hi_r <= cnt_r))
    else $error("search window out of order");

  // Writing the new score grows the set by one
  a_put_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the set");

  // Table writes (shifts and the new score) only happen on a non-full, non-duplicate insert
  a_shift_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (op_r == ACT_INSERT && !eq_r && !full))
    else $error("table write outside a legal insert");

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the dense rank lookup block.
`timescale 1ns / 1ps
module tb;
  import drl_pkg::*;

  // Action code that the block ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 500;
  localparam int CALM_AFTER   = 440;
  // Longest insert: full search plus a shift of every stored score.
  localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 500;
  localparam int WD_LIMIT     = 20000;
  localparam logic [31:0] FILL_STEP = 32'd4000000;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              overflowed;
  } rank_word_t;

  // Tracks the sorted score set and the rank words it should produce.
  class rank_scoreboard;
    logic [31:0] scores[$];
    logic        drop_seen;
    rank_word_t  expected_q[$];
    int          errors;

    function new();
      drop_seen = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply one accepted input word to the shadow set.
    function void note_word(logic [ACTION_W-1:0] action, logic [31:0] score);
      int         pos;
      int         greater;
      rank_word_t w;
      pos     = 0;
      greater = 0;
      case (action)
        ACT_CLEAR: begin
          scores.delete();
          drop_seen = 1'b0;
        end
        ACT_INSERT: begin
          while (pos < scores.size() && scores[pos] < score) pos++;
          if (pos < scores.size() && scores[pos] == score) return;
          if (scores.size() >= TABLE_DEPTH) begin
            drop_seen = 1'b1;
            return;
          end
          scores.insert(pos, score);
        end
        ACT_QUERY: begin
          foreach (scores[i]) if (scores[i] > score) greater++;
          w.rank       = RANK_W'(greater + 1);
          w.overflowed = drop_seen;
          expected_q.push_back(w);
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result word with the oldest expectation.
    task check_result(logic [RANK_W-1:0] rank, logic overflowed);
      rank_word_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("rank word %0d arrived with no query waiting", rank));
        return;
      end
      want = expected_q.pop_front();
      if (rank !== want.rank)
        report($sformatf("rank got %0d want %0d", rank, want.rank));
      if (overflowed !== want.overflowed)
        report($sformatf("overflowed got %b want %b", overflowed, want.overflowed));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = ACT_CLEAR;
  logic [31:0]         in_score = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RANK_W-1:0]   out_rank;
  logic                out_overflowed;

  rank_scoreboard sb = new();
  bit  in_idle_en  = 1'b1;
  bit  out_idle_en = 1'b1;
  bit  calm        = 1'b0;
  bit  wd_armed    = 1'b0;
  int  sent_count  = 0;
  int  idle_cycles = 0;
  int  stall_left  = 0;

  dense_rank_lookup u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_score       (in_score),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rank       (out_rank),
    .out_overflowed (out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check every accepted result word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_rank, out_overflowed);
  end

  // Stall the result side in short random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (out_idle_en && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // End the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (wd_armed) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one input word, hold it until accepted, then record it.
  task automatic send_word(logic [ACTION_W-1:0] action, logic [31:0] score);
    int gap;
    @(negedge clk);
    if (in_idle_en && !calm && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 4);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_action = action;
    in_score  = score;
    do @(posedge clk); while (!in_ready);
    sb.note_word(action, score);
    if (action != ACT_UNUSED) sent_count++;
  endtask

  task automatic run_directed();
    // Empty set, extremes of the score.
    send_word(ACT_QUERY, 32'h0000_0000);
    send_word(ACT_QUERY, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'd100);
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'h0000_0000);
    // Duplicate insert is dropped silently.
    send_word(ACT_INSERT, 32'd100);
    send_word(ACT_INSERT, 32'd50);
    // Equal (including the lowest and highest stored scores) and in-between queries.
    send_word(ACT_QUERY, 32'd100);
    send_word(ACT_QUERY, 32'h0000_0000);
    send_word(ACT_QUERY, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 32'hFFFF_FFFE);
    send_word(ACT_QUERY, 32'd75);
    // Unused action code leaves the set alone.
    send_word(ACT_UNUSED, 32'd5);
    send_word(ACT_QUERY, 32'd5);
    send_word(ACT_CLEAR, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 32'd100);
    send_word(ACT_INSERT, 32'h8000_0000);
    send_word(ACT_QUERY, 32'h7FFF_FFFF);
    send_word(ACT_QUERY, 32'h8000_0001);
    send_word(ACT_QUERY, 32'h8000_0000);
  endtask

  // Random mix of inserts, queries, unused codes and clears over a small pool of scores.
  task automatic run_mixed_segment();
    logic [31:0] pool[16];
    logic [31:0] v;
    int          psz;
    int          n;
    int          r;
    psz         = $urandom_range(2, 16);
    n           = $urandom_range(5, 40);
    in_idle_en  = ($urandom_range(0, 3) != 0);
    out_idle_en = ($urandom_range(0, 3) != 0);
    for (int k = 0; k < psz; k++) begin
      case ($urandom_range(0, 3))
        0:       pool[k] = $urandom_range(0, 15);
        1:       pool[k] = 32'hFFFF_FFFF - $urandom_range(0, 15);
        default: pool[k] = $urandom;
      endcase
    end
    if ($urandom_range(0, 4) != 0) send_word(ACT_CLEAR, $urandom);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      v = pool[$urandom_range(0, psz - 1)];
      if (r < 45) begin
        send_word(ACT_INSERT, v);
      end else if (r < 92) begin
        case ($urandom_range(0, 3))
          0:       v = v + 32'd1;
          1:       v = v - 32'd1;
          2:       v = $urandom;
          default: ;
        endcase
        send_word(ACT_QUERY, v);
      end else if (r < 96) begin
        send_word(ACT_UNUSED, $urandom);
      end else begin
        send_word(ACT_CLEAR, $urandom);
      end
    end
  endtask

  // Fill the table in ascending order, then drive it past capacity.
  task automatic run_fill_segment();
    logic [31:0] v;
    logic [31:0] lo_v;
    logic [31:0] hi_v;
    lo_v = '0;
    hi_v = '0;
    send_word(ACT_CLEAR, 32'd0);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      v = 32'(k + 1) * FILL_STEP + $urandom_range(0, 3999999);
      if (k == 0) lo_v = v;
      hi_v = v;
      send_word(ACT_INSERT, v);
      if ($urandom_range(0, 15) == 0) send_word(ACT_INSERT, v);
      if ($urandom_range(0, 15) == 0) send_word(ACT_QUERY, $urandom);
    end
    // Full but no overflow yet.
    send_word(ACT_QUERY, 32'h0000_0000);
    send_word(ACT_QUERY, hi_v);
    send_word(ACT_QUERY, lo_v);
    send_word(ACT_QUERY, 32'hFFFF_FFFF);
    // Duplicate while full does not raise the flag.
    send_word(ACT_INSERT, hi_v);
    send_word(ACT_QUERY, 32'h0000_0000);
    // New scores while full are dropped and raise the flag.
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 32'h0000_0000);
    send_word(ACT_INSERT, 32'h0000_0000);
    send_word(ACT_INSERT, $urandom);
    for (int k = 0; k < 6; k++) send_word(ACT_QUERY, $urandom);
    send_word(ACT_QUERY, 32'hFFFF_FFFF);
    // Clear drops the flag too.
    send_word(ACT_CLEAR, $urandom);
    send_word(ACT_QUERY, $urandom);
  endtask

  initial begin
    int seg;
    int base;
    seg = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n    = 1'b1;
    wd_armed = 1'b1;

    run_directed();
    sent_count = 0;
    while (sent_count < RANDOM_WORDS) begin
      if (seg == 2) begin
        base = sent_count;
        run_fill_segment();
        sent_count = base;
      end else begin
        run_mixed_segment();
      end
      if (sent_count >= CALM_AFTER) calm = 1'b1;
      seg++;
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then give a last insert time to settle.
    while (sb.pending() != 0) @(posedge clk);
    wd_armed = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/drl_pkg.sv
rtl/core/dense_rank_lookup.sv
tb/tb.sv
